// ===== design/sbq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sbq_pkg - shared types and constants of the stereo biquad filter
// Widths, register indexes, controller states and the command bundle that
// links the sequencer to the datapath.
// ============================================================================
package sbq_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 24;

  localparam int COEF_BITS      = 32;
  localparam int GAIN_BITS      = 17;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int Y_BITS         = 32;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_IDX_W      = 3;

  // Shared multiplier: 33x33 signed covers coef*sample, coef*y and y*gain
  localparam int MUL_W  = 33;
  localparam int PROD_W = 64;
  localparam int ACC_W  = PROD_W + 3;

  localparam int NUM_TAPS = 5;
  localparam int TAP_W    = $clog2(NUM_TAPS + 1);

  localparam logic [CFG_IDX_W-1:0] REG_B0     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_B1     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_B2     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_FB1    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_FB2    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS = CFG_IDX_W'(6);

  localparam logic [COEF_BITS-1:0] B0_RESET   = COEF_BITS'(1) << COEF_FRAC_BITS;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(1) << GAIN_FRAC_BITS;

  localparam logic [Y_BITS-1:0] Y_MAX = {1'b0, {(Y_BITS - 1){1'b1}}};
  localparam logic [Y_BITS-1:0] Y_MIN = {1'b1, {(Y_BITS - 1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  typedef struct packed {
    logic signed [COEF_BITS-1:0] b0;
    logic signed [COEF_BITS-1:0] b1;
    logic signed [COEF_BITS-1:0] b2;
    logic signed [COEF_BITS-1:0] fb1;
    logic signed [COEF_BITS-1:0] fb2;
    logic [GAIN_BITS-1:0]        gain;
    logic                        bypass;
  } cfg_t;

  typedef enum logic [2:0] {
    SEL_B0,
    SEL_B1,
    SEL_B2,
    SEL_FB1,
    SEL_FB2,
    SEL_GAIN
  } mul_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_ROUND,
    ST_GAIN,
    ST_SCALE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_clear;
    logic     acc_en;
    logic     round_en;
    logic     scale_en;
    logic     ch;
    logic     out_load;
  } cmd_t;

endpackage
`default_nettype wire

// ===== design/sbq_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sbq_cfg_regs - configuration register file
// Holds the coefficients, output gain and bypass flag; unknown indexes drop.
// ============================================================================
module sbq_cfg_regs (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_we,
  input  wire  [sbq_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [sbq_pkg::CFG_DATA_W-1:0]        cfg_data,
  output sbq_pkg::cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.b0     <= sbq_pkg::B0_RESET;
      cfg.b1     <= '0;
      cfg.b2     <= '0;
      cfg.fb1    <= '0;
      cfg.fb2    <= '0;
      cfg.gain   <= sbq_pkg::GAIN_RESET;
      cfg.bypass <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sbq_pkg::REG_B0:     cfg.b0     <= cfg_data[sbq_pkg::COEF_BITS-1:0];
        sbq_pkg::REG_B1:     cfg.b1     <= cfg_data[sbq_pkg::COEF_BITS-1:0];
        sbq_pkg::REG_B2:     cfg.b2     <= cfg_data[sbq_pkg::COEF_BITS-1:0];
        sbq_pkg::REG_FB1:    cfg.fb1    <= cfg_data[sbq_pkg::COEF_BITS-1:0];
        sbq_pkg::REG_FB2:    cfg.fb2    <= cfg_data[sbq_pkg::COEF_BITS-1:0];
        sbq_pkg::REG_GAIN:   cfg.gain   <= cfg_data[sbq_pkg::GAIN_BITS-1:0];
        sbq_pkg::REG_BYPASS: cfg.bypass <= cfg_data[0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/sbq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sbq_ctrl - sequencer of the stereo biquad
// Steps both channels through five multiply-accumulate taps, rounding and
// gain (skipped in bypass), then hands the transaction to the output register.
// ============================================================================
module sbq_ctrl (
  input  wire           clk,
  input  wire           rst,
  input  wire           in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire           out_ready,
  input  wire           bypass,
  output sbq_pkg::cmd_t cmd
);

  sbq_pkg::state_t                 state, state_next;
  logic [sbq_pkg::TAP_W-1:0]       tap, tap_next;
  logic                            ch, ch_next;
  logic                            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sbq_pkg::ST_IDLE;
      tap       <= '0;
      ch        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      tap       <= tap_next;
      ch        <= ch_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    tap_next       = tap;
    ch_next        = ch;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.mul_sel    = sbq_pkg::SEL_B0;
    cmd.ch         = ch;
    case (state)
      sbq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        tap_next = '0;
        ch_next  = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = bypass ? sbq_pkg::ST_OUT : sbq_pkg::ST_MAC;
        end
      end
      sbq_pkg::ST_MAC: begin
        // issue a product on taps 0..4, fold it into the sum in the next cycle
        cmd.mul_en    = (tap != sbq_pkg::TAP_W'(sbq_pkg::NUM_TAPS));
        cmd.acc_clear = (tap == '0);
        cmd.acc_en    = (tap != '0);
        case (tap)
          sbq_pkg::TAP_W'(0): cmd.mul_sel = sbq_pkg::SEL_B0;
          sbq_pkg::TAP_W'(1): cmd.mul_sel = sbq_pkg::SEL_B1;
          sbq_pkg::TAP_W'(2): cmd.mul_sel = sbq_pkg::SEL_B2;
          sbq_pkg::TAP_W'(3): cmd.mul_sel = sbq_pkg::SEL_FB1;
          default:            cmd.mul_sel = sbq_pkg::SEL_FB2;
        endcase
        tap_next = tap + 1'b1;
        if (tap == sbq_pkg::TAP_W'(sbq_pkg::NUM_TAPS)) begin
          state_next = sbq_pkg::ST_ROUND;
        end
      end
      sbq_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
        state_next   = sbq_pkg::ST_GAIN;
      end
      sbq_pkg::ST_GAIN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = sbq_pkg::SEL_GAIN;
        state_next  = sbq_pkg::ST_SCALE;
      end
      sbq_pkg::ST_SCALE: begin
        cmd.scale_en = 1'b1;
        tap_next     = '0;
        if (!ch) begin
          ch_next    = 1'b1;
          state_next = sbq_pkg::ST_MAC;
        end else begin
          state_next = sbq_pkg::ST_OUT;
        end
      end
      sbq_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = sbq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sbq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/sbq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sbq_datapath - shared multiplier, accumulator and history of both channels
// One registered multiplier feeds a wide accumulator; rounding, saturation
// and the output register follow.
// ============================================================================
module sbq_datapath (
  input  wire                                   clk,
  input  wire                                   rst,
  input  sbq_pkg::cfg_t                         cfg,
  input  sbq_pkg::cmd_t                         cmd,
  input  wire  signed [sbq_pkg::SAMPLE_BITS-1:0] left_sample,
  input  wire  signed [sbq_pkg::SAMPLE_BITS-1:0] right_sample,
  input  wire                                   block_last,
  output logic signed [sbq_pkg::SAMPLE_BITS-1:0] left_out,
  output logic signed [sbq_pkg::SAMPLE_BITS-1:0] right_out,
  output logic                                  block_last_out
);

  localparam int SB = sbq_pkg::SAMPLE_BITS;
  localparam int MW = sbq_pkg::MUL_W;
  localparam int PW = sbq_pkg::PROD_W;
  localparam int AW = sbq_pkg::ACC_W;
  localparam int YB = sbq_pkg::Y_BITS;

  logic signed [SB-1:0] x_in [2];
  logic                 last_in;
  logic signed [SB-1:0] x1 [2];
  logic signed [SB-1:0] x2 [2];
  logic signed [YB-1:0] y1 [2];
  logic signed [YB-1:0] y2 [2];
  logic signed [YB-1:0] y_reg;
  logic signed [SB-1:0] res [2];

  logic signed [MW-1:0]   op_a, op_b;
  logic signed [2*MW-1:0] mul_full;
  logic signed [PW-1:0]   prod;
  logic signed [AW-1:0]   acc;

  logic signed [AW-1:0] acc_rnd, q;
  logic                 q_fits;
  logic signed [YB-1:0] y_new;
  logic signed [PW-1:0] s_rnd, s;
  logic                 s_fits;
  logic signed [SB-1:0] s_sat;

  function automatic logic signed [MW-1:0] sext_coef(input logic [sbq_pkg::COEF_BITS-1:0] v);
    return {{(MW - sbq_pkg::COEF_BITS){v[sbq_pkg::COEF_BITS-1]}}, v};
  endfunction

  function automatic logic signed [MW-1:0] sext_smp(input logic [SB-1:0] v);
    return {{(MW - SB){v[SB-1]}}, v};
  endfunction

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      sbq_pkg::SEL_B0: begin
        op_a = sext_coef(cfg.b0);
        op_b = sext_smp(x_in[cmd.ch]);
      end
      sbq_pkg::SEL_B1: begin
        op_a = sext_coef(cfg.b1);
        op_b = sext_smp(x1[cmd.ch]);
      end
      sbq_pkg::SEL_B2: begin
        op_a = sext_coef(cfg.b2);
        op_b = sext_smp(x2[cmd.ch]);
      end
      sbq_pkg::SEL_FB1: begin
        op_a = sext_coef(cfg.fb1);
        op_b = {{(MW - YB){y1[cmd.ch][YB-1]}}, y1[cmd.ch]};
      end
      sbq_pkg::SEL_FB2: begin
        op_a = sext_coef(cfg.fb2);
        op_b = {{(MW - YB){y2[cmd.ch][YB-1]}}, y2[cmd.ch]};
      end
      sbq_pkg::SEL_GAIN: begin
        op_a = {{(MW - YB){y_reg[YB-1]}}, y_reg};
        op_b = {{(MW - sbq_pkg::GAIN_BITS){1'b0}}, cfg.gain};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_full = op_a * op_b;

  // round half up, then saturate the filter output to 32 bits
  always_comb begin
    acc_rnd = acc + (AW'(1) << (sbq_pkg::COEF_FRAC_BITS - 1));
    q       = acc_rnd >>> sbq_pkg::COEF_FRAC_BITS;
    q_fits  = (&q[AW-1:YB-1]) | ~(|q[AW-1:YB-1]);
    y_new   = q_fits ? q[YB-1:0] : (q[AW-1] ? sbq_pkg::Y_MIN : sbq_pkg::Y_MAX);
  end

  // apply gain rounding and saturate to the sample width
  always_comb begin
    s_rnd  = prod + (PW'(1) << (sbq_pkg::GAIN_FRAC_BITS - 1));
    s      = s_rnd >>> sbq_pkg::GAIN_FRAC_BITS;
    s_fits = (&s[PW-1:SB-1]) | ~(|s[PW-1:SB-1]);
    s_sat  = s_fits ? s[SB-1:0] : (s[PW-1] ? sbq_pkg::S_MIN : sbq_pkg::S_MAX);
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_in[0] <= left_sample;
      x_in[1] <= right_sample;
      last_in <= block_last;
    end
    if (cmd.mul_en) begin
      prod <= mul_full[PW-1:0];
    end
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc + {{(AW - PW){prod[PW-1]}}, prod};
    end
    if (cmd.round_en) begin
      y_reg <= y_new;
    end
    if (cmd.scale_en) begin
      res[cmd.ch] <= s_sat;
    end
    if (cmd.out_load) begin
      left_out       <= cfg.bypass ? x_in[0] : res[0];
      right_out      <= cfg.bypass ? x_in[1] : res[1];
      block_last_out <= last_in;
    end
  end

  // filter history, cleared by reset only
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        x1[i] <= '0;
        x2[i] <= '0;
        y1[i] <= '0;
        y2[i] <= '0;
      end
    end else if (cmd.round_en) begin
      x2[cmd.ch] <= x1[cmd.ch];
      x1[cmd.ch] <= x_in[cmd.ch];
      y2[cmd.ch] <= y1[cmd.ch];
      y1[cmd.ch] <= y_new;
    end
  end

endmodule
`default_nettype wire

// ===== design/stereo_biquad_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// stereo_biquad_filter - two-channel direct-form-I biquad with output gain
// Filters a stereo sample pair per transaction with shared coefficients,
// then applies a Q1.16 post gain with rounding and saturation.
// ============================================================================
// One transaction carries a stereo pair and returns one filtered pair. Both
// channels go through a single shared 33x33 multiplier: per channel five
// multiply-accumulate taps and a drain of the last product, rounding and
// saturation of the filter output into the history, one gain multiply, and
// rounding and saturation to the sample width. The accept comes first and
// the output load last; in bypass the accept leads straight to the output
// load. The block takes one pair at a time (in_ready is high only while
// the sequencer is idle), but the result sits in its own output register,
// so the next pair is accepted and processed while the previous result
// waits for out_ready. Coefficients are signed Q8.24, the gain unsigned
// Q1.16 (65536 is unity); the filter history keeps the 32-bit filter output
// before gain. Write configuration only while no transaction is in flight.
// The history is cleared by reset only; bypass freezes it.
// ============================================================================
module stereo_biquad_filter (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    cfg_we,
  input  wire  [sbq_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire  [sbq_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire  signed [sbq_pkg::SAMPLE_BITS-1:0] left_sample,
  input  wire  signed [sbq_pkg::SAMPLE_BITS-1:0] right_sample,
  input  wire                                    block_last,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic signed [sbq_pkg::SAMPLE_BITS-1:0] left_out,
  output logic signed [sbq_pkg::SAMPLE_BITS-1:0] right_out,
  output logic                                   block_last_out
);

  sbq_pkg::cfg_t cfg;
  sbq_pkg::cmd_t cmd;

  // register file: coefficients, gain, bypass
  sbq_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: owns both handshakes and issues datapath commands
  sbq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .bypass    (cfg.bypass),
    .cmd       (cmd)
  );

  // arithmetic, history and output register
  sbq_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .left_sample    (left_sample),
    .right_sample   (right_sample),
    .block_last     (block_last),
    .left_out       (left_out),
    .right_out      (right_out),
    .block_last_out (block_last_out)
  );

`ifndef NO_ASSERTIONS
  // latch inputs only on a real transaction
  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |-> (in_valid && in_ready))
    else $error("input latched without an accepted transaction");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten while still pending");

  // a loaded result is presented in the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  // sequencing phases are mutually exclusive
  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_in, cmd.round_en, cmd.scale_en, cmd.out_load}))
    else $error("overlapping sequencer phases");
`endif

endmodule
`default_nettype wire
